[src/cgpg_pkg.sv]
`timescale 1ns / 1ps

package cgpg_pkg;

  localparam int MaxRowsDefault    = 1024;
  localparam int MaxColumnsDefault = 1024;
  localparam int CoordBitsDefault  = 24;

  localparam int CordicSteps = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Arctangent of 2^-k in units of 2^-32 turn.
  localparam logic signed [32:0] AtanTurns [CordicSteps] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  typedef enum logic [2:0] {
    REG_HALF_HEIGHT  = 3'd0,
    REG_RADIUS       = 3'd1,
    REG_ROW_COUNT    = 3'd2,
    REG_COLUMN_COUNT = 3'd3,
    REG_SKEW_AMOUNT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quadrant_e;

  // Per-item fields that ride alongside the arithmetic.
  typedef struct packed {
    logic signed [24:0] height;
    logic [19:0]        point_index;
    logic               index_error;
  } point_side_t;

endpackage

[src/cylindrical_grid_point_generator.sv]
`timescale 1ns / 1ps

// Channel   | Dir | Signals                          | Contents
// s_axis    | in  | tvalid, tready, tdata[23:0]      | row_index, column_index
// m_axis    | out | tvalid, tready, tdata            | x, y, z, point_index, index_error
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i  | register writes
//
// One point per cycle is accepted and delivered while the output is not stalled;
// the path runs through the 39-stage row divider, the 45-stage phase divider and the 24 CORDIC stages.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall holds every stage in place.
module cylindrical_grid_point_generator #(
  parameter int MAX_ROWS    = cgpg_pkg::MaxRowsDefault,
  parameter int MAX_COLUMNS = cgpg_pkg::MaxColumnsDefault,
  parameter int COORD_BITS  = cgpg_pkg::CoordBitsDefault,
  localparam int OUT_W = ((3 * COORD_BITS + 21 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // row_index[9:0], column_index[19:10], zero padding
  input  logic [23:0]      s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // x_coord, y_coord, z_coord (COORD_BITS each), point_index[19:0], index_error
  output logic [OUT_W-1:0] m_axis_tdata_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [23:0]      cfg_data_i
);

  localparam int NUM1_W = 38;
  localparam int NUM2_W = 44;
  localparam int SIDE1_W = 34;
  localparam int SIDE2_W = $bits(cgpg_pkg::point_side_t) + 1;
  localparam logic signed [49:0] CHI = (50'sd1 <<< (COORD_BITS - 1)) - 50'sd1;
  localparam logic signed [49:0] CLO = -CHI - 50'sd1;

  // Configuration registers.
  logic signed [23:0] half_height_q;
  logic [22:0]        radius_q;
  logic [10:0]        row_count_q;
  logic [10:0]        column_count_q;
  logic signed [23:0] skew_amount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_height_q  <= '0;
      radius_q       <= '0;
      row_count_q    <= 11'd1;
      column_count_q <= 11'd1;
      skew_amount_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cgpg_pkg::REG_HALF_HEIGHT:  half_height_q  <= cfg_data_i;
        cgpg_pkg::REG_RADIUS:       radius_q       <= cfg_data_i[22:0];
        cgpg_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i[10:0];
        cgpg_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data_i[10:0];
        cgpg_pkg::REG_SKEW_AMOUNT:  skew_amount_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input stage: index checks, row offset products and linear index.
  logic [9:0]         in_row;
  logic [9:0]         in_col;
  logic signed [12:0] t_row;
  logic               in_err;

  assign in_row = s_axis_tdata_i[9:0];
  assign in_col = s_axis_tdata_i[19:10];
  assign t_row  = $signed({2'b00, in_row, 1'b0}) - $signed({2'b00, row_count_q}) + 13'sd1;
  assign in_err = (row_count_q == '0) || (column_count_q == '0)
               || (32'(row_count_q) > MAX_ROWS) || (32'(column_count_q) > MAX_COLUMNS)
               || ({1'b0, in_row} >= row_count_q) || ({1'b0, in_col} >= column_count_q);

  logic               p1_valid_q;
  logic signed [36:0] p1_prod_h_q;
  logic signed [36:0] p1_prod_s_q;
  logic [9:0]         p1_col_q;
  logic [19:0]        p1_pidx_q;
  logic               p1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_prod_h_q <= half_height_q * t_row;
      p1_prod_s_q <= skew_amount_q * t_row;
      p1_col_q    <= in_col;
      p1_pidx_q   <= 20'(in_row * column_count_q + {1'b0, in_col});
      p1_err_q    <= in_err;
    end
  end

  // Height and skew both divide by 2(m-1): the height numerator is doubled.
  logic [10:0]        rows_m1;
  logic [35:0]        mag_h;
  logic [35:0]        mag_s;
  logic [NUM1_W-1:0]  div1_num [2];
  logic [NUM1_W-1:0]  div1_quo [2];
  logic [SIDE1_W-1:0] div1_side_in;
  logic [SIDE1_W-1:0] div1_side_out;
  logic               div1_valid;

  assign rows_m1 = row_count_q - 11'd1;
  assign mag_h   = p1_prod_h_q[36] ? 36'(-p1_prod_h_q) : p1_prod_h_q[35:0];
  assign mag_s   = p1_prod_s_q[36] ? 36'(-p1_prod_s_q) : p1_prod_s_q[35:0];
  assign div1_num[0] = NUM1_W'({mag_h, 1'b0}) + NUM1_W'(rows_m1);
  assign div1_num[1] = NUM1_W'(mag_s) + NUM1_W'(rows_m1);
  assign div1_side_in = {p1_prod_h_q[36], p1_prod_s_q[36], (row_count_q > 11'd1),
                         p1_col_q, p1_pidx_q, p1_err_q};

  cgpg_div #(
    .NUM_W (NUM1_W),
    .DEN_W (12),
    .LANES (2),
    .SIDE_W(SIDE1_W)
  ) u_row_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(p1_valid_q),
    .num_i  (div1_num),
    .den_i  ({rows_m1, 1'b0}),
    .side_i (div1_side_in),
    .valid_o(div1_valid),
    .quo_o  (div1_quo),
    .side_o (div1_side_out)
  );

  // Rebuild signed height and skew, then form the phase numerator.
  logic               d1_neg_h;
  logic               d1_neg_s;
  logic               d1_multi;
  logic [9:0]         d1_col;
  logic [19:0]        d1_pidx;
  logic               d1_err;
  logic signed [24:0] hmag;
  logic signed [24:0] smag;
  logic signed [24:0] height;
  logic signed [24:0] skew16;
  logic signed [27:0] ang;
  logic [26:0]        ang_mag;
  logic [NUM2_W-1:0]  div2_num [1];
  logic [NUM2_W-1:0]  div2_quo [1];
  cgpg_pkg::point_side_t side2;
  logic [SIDE2_W-1:0] div2_side_out;
  logic               div2_valid;

  assign {d1_neg_h, d1_neg_s, d1_multi, d1_col, d1_pidx, d1_err} = div1_side_out;
  assign hmag   = $signed({1'b0, div1_quo[0][23:0]});
  assign smag   = $signed({1'b0, div1_quo[1][23:0]});
  assign height = !d1_multi ? '0 : (d1_neg_h ? -hmag : hmag);
  assign skew16 = !d1_multi ? '0 : (d1_neg_s ? -smag : smag);
  assign ang     = $signed({2'b00, d1_col, 16'h0000}) + 28'(skew16);
  assign ang_mag = ang[27] ? 27'(-ang) : ang[26:0];
  assign div2_num[0] = NUM2_W'({ang_mag, 16'h0000}) + NUM2_W'(column_count_q[10:1]);
  assign side2.height      = height;
  assign side2.point_index = d1_pidx;
  assign side2.index_error = d1_err;

  cgpg_div #(
    .NUM_W (NUM2_W),
    .DEN_W (11),
    .LANES (1),
    .SIDE_W(SIDE2_W)
  ) u_phase_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(div1_valid),
    .num_i  (div2_num),
    .den_i  (column_count_q),
    .side_i ({ang[27], side2}),
    .valid_o(div2_valid),
    .quo_o  (div2_quo),
    .side_o (div2_side_out)
  );

  logic [31:0] phase;
  assign phase = div2_side_out[SIDE2_W-1] ? 32'(-div2_quo[0][31:0]) : div2_quo[0][31:0];

  // CORDIC rotation over the low 30 phase bits.
  localparam int NS = cgpg_pkg::CordicSteps;

  logic [NS:0]               cv_q;
  logic signed [33:0]        cx_q [NS+1];
  logic signed [33:0]        cy_q [NS+1];
  logic signed [32:0]        cz_q [NS+1];
  logic [1:0]                cquad_q [NS+1];
  cgpg_pkg::point_side_t     cside_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en) begin
      cv_q <= {cv_q[NS-1:0], div2_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]    <= cgpg_pkg::CordicGain;
      cy_q[0]    <= '0;
      cz_q[0]    <= $signed({3'b000, phase[29:0]});
      cquad_q[0] <= phase[31:30];
      cside_q[0] <= div2_side_out[SIDE2_W-2:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = cy_q[k] >>> k;
    assign dy = cx_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!cz_q[k][32]) begin
          cx_q[k+1] <= cx_q[k] - dx;
          cy_q[k+1] <= cy_q[k] + dy;
          cz_q[k+1] <= cz_q[k] - cgpg_pkg::AtanTurns[k];
        end else begin
          cx_q[k+1] <= cx_q[k] + dx;
          cy_q[k+1] <= cy_q[k] - dy;
          cz_q[k+1] <= cz_q[k] + cgpg_pkg::AtanTurns[k];
        end
        cquad_q[k+1] <= cquad_q[k];
        cside_q[k+1] <= cside_q[k];
      end
    end
  end

  // Round to Q1.16, clamp to one, map to the quadrant.
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [17:0] c16;
  logic signed [17:0] s16;
  logic signed [17:0] cos_d;
  logic signed [17:0] sin_d;

  assign xr  = (cx_q[NS] + 34'sd8192) >>> 14;
  assign yr  = (cy_q[NS] + 34'sd8192) >>> 14;
  assign c16 = (xr > 34'sd65536) ? 18'sd65536 : ((xr < -34'sd65536) ? -18'sd65536 : xr[17:0]);
  assign s16 = (yr > 34'sd65536) ? 18'sd65536 : ((yr < -34'sd65536) ? -18'sd65536 : yr[17:0]);

  always_comb begin
    case (cgpg_pkg::quadrant_e'(cquad_q[NS]))
      cgpg_pkg::QUAD_FIRST: begin
        cos_d = c16;
        sin_d = s16;
      end
      cgpg_pkg::QUAD_SECOND: begin
        cos_d = -s16;
        sin_d = c16;
      end
      cgpg_pkg::QUAD_THIRD: begin
        cos_d = -c16;
        sin_d = -s16;
      end
      default: begin
        cos_d = s16;
        sin_d = -c16;
      end
    endcase
  end

  logic                  q1_valid_q;
  logic signed [17:0]    q1_cos_q;
  logic signed [17:0]    q1_sin_q;
  cgpg_pkg::point_side_t q1_side_q;
  logic                  q2_valid_q;
  logic signed [41:0]    q2_px_q;
  logic signed [41:0]    q2_py_q;
  cgpg_pkg::point_side_t q2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_valid_q <= 1'b0;
      q2_valid_q <= 1'b0;
    end else if (en) begin
      q1_valid_q <= cv_q[NS];
      q2_valid_q <= q1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_cos_q  <= cos_d;
      q1_sin_q  <= sin_d;
      q1_side_q <= cside_q[NS];
      q2_px_q   <= $signed({1'b0, radius_q}) * q1_cos_q;
      q2_py_q   <= $signed({1'b0, radius_q}) * q1_sin_q;
      q2_side_q <= q1_side_q;
    end
  end

  function automatic logic signed [25:0] round_q16(input logic signed [41:0] v);
    logic signed [42:0] w;
    logic signed [42:0] r;
    w = 43'(v);
    if (!w[42]) begin
      r = (w + 43'sd32768) >>> 16;
    end else begin
      r = -((-w + 43'sd32768) >>> 16);
    end
    return r[25:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [25:0] v);
    logic signed [49:0] w;
    w = 50'(v);
    if (w > CHI) begin
      w = CHI;
    end else if (w < CLO) begin
      w = CLO;
    end
    return w[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0] x_d;
  logic [COORD_BITS-1:0] y_d;
  logic [COORD_BITS-1:0] z_d;
  logic [OUT_W-1:0]      out_data_d;
  logic [OUT_W-1:0]      out_data_q;

  assign x_d = sat_coord(round_q16(q2_px_q));
  assign y_d = sat_coord(round_q16(q2_py_q));
  assign z_d = sat_coord(26'(q2_side_q.height));
  assign out_data_d = q2_side_q.index_error
                    ? OUT_W'({1'b1, 20'h0, {(3 * COORD_BITS){1'b0}}})
                    : OUT_W'({1'b0, q2_side_q.point_index, z_d, y_d, x_d});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= q2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  localparam int ERR_BIT = 3 * COORD_BITS + 20;

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[ERR_BIT] |-> (out_data_q[ERR_BIT-1:0] == '0))
    else $error("error result carries non-zero fields");

  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (radius_q == '0)
      |-> (out_data_q[2*COORD_BITS-1:0] == '0))
    else $error("zero radius gave non-zero x or y");

  a_single_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (row_count_q == 11'd1)
      |-> (out_data_q[3*COORD_BITS-1:2*COORD_BITS] == '0))
    else $error("single row gave non-zero height");

endmodule

[src/cgpg_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per pipeline stage, several numerators
// sharing one divisor. The divisor must stay constant while items are in flight.
module cgpg_div #(
  parameter int NUM_W  = 38,
  parameter int DEN_W  = 12,
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]    valid_q;
  logic [SIDE_W-1:0] side_q [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NUM_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= NUM_W; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DEN_W-1:0] rem_q [NUM_W+1];
    logic [NUM_W-1:0] acc_q [NUM_W+1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= '0;
        acc_q[0] <= num_i[l];
      end
    end

    // The numerator shifts out at the top while quotient bits fill in below.
    for (genvar s = 1; s <= NUM_W; s++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      assign trial = {rem_q[s-1], acc_q[s-1][NUM_W-1]};
      assign diff  = trial - {1'b0, den_i};
      assign ge    = (trial >= {1'b0, den_i});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          acc_q[s] <= {acc_q[s-1][NUM_W-2:0], ge};
        end
      end
    end

    assign quo_o[l] = acc_q[NUM_W];
  end

  assign valid_o = valid_q[NUM_W];
  assign side_o  = side_q[NUM_W];

endmodule
